FILE: src/gbfs_pkg.sv
// Shared types and constants for the greedy best-first graph search block.
package gbfs_pkg;

    localparam int NODE_FW  = 5;
    localparam int HEUR_FW  = 16;
    localparam int CMD_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SETH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD,
        S_SCAN,
        S_PICK,
        S_ADJ_RD,
        S_EXPAND,
        S_BT_WR,
        S_BT_RD,
        S_EM_RD,
        S_EM_LD,
        S_EM_OUT,
        S_FAIL
    } t_state;

endpackage

FILE: src/gbfs_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module gbfs_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gbfs_minu.sv
// Running minimum unit over (heuristic, node index) candidates, one per cycle.
module gbfs_minu #(
    parameter int HW = 16,
    parameter int NW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_valid,
    input  logic [HW-1:0] i_heur,
    input  logic [NW-1:0] i_idx,
    output logic [NW-1:0] o_idx
);

    logic          r_have;
    logic [HW-1:0] r_best_h;
    logic [NW-1:0] r_best_idx;
    logic          take;

    // candidates arrive in rising index order, so strict less keeps the lowest index on ties
    assign take = i_valid && (!r_have || (i_heur < r_best_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_clear) begin
            r_best_h   <= i_heur;
            r_best_idx <= i_idx;
        end
    end

    assign o_idx = r_best_idx;

endmodule

FILE: src/greedy_best_first_graph_search.sv
// Top level: graph store, search sequencer and path output of the best-first search.
//
//  channel  dir  fields (lowest bit first)                               ends on
//  s_axis   in   tuser: command; tdata: first_node, second_node, heur    tvalid & tready
//  m_axis   out  tdata: path_node; tuser: found; tlast: last             tvalid & tready
//
//  Clear and set-heuristic finish in the idle state; add-edge writes in S_EDGE_RD.
//  Per expanded node a search makes one pass of the shared min unit over the
//  heuristic RAM, then one parent RAM write slot per node. Backtrack steps through
//  S_BT_WR and S_BT_RD per path node, output through S_EM_RD to S_EM_OUT plus stalls.
//  Reset is synchronous; it empties the graph at once through per-row valid bits.
//  s_axis_tready is high only while idle; results wait in an output register.
module greedy_best_first_graph_search #(
    parameter int NODE_COUNT = 32,
    parameter int HEUR_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gbfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // first_node, second_node, heur
    input  logic [gbfs_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gbfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // path_node
    output logic                               m_axis_tuser,  // found
    output logic                               m_axis_tlast
);
    import gbfs_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);

    t_state r_state, n_state;

    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_len, n_len;
    logic [CW-1:0]         r_k, n_k;
    logic [NODE_COUNT-1:0] r_open, n_open;
    logic [NODE_COUNT-1:0] r_closed, n_closed;
    logic [NODE_COUNT-1:0] r_new, n_new;
    logic [NW-1:0]         r_u, n_u;
    logic [NW-1:0]         r_x, n_x;
    logic [NW-1:0]         r_start, n_start;
    logic [NW-1:0]         r_goal, n_goal;
    logic [NW-1:0]         r_ea, n_ea;
    logic [NW-1:0]         r_eb, n_eb;
    logic [NODE_COUNT-1:0] r_adj_vld, n_adj_vld;
    logic [NODE_COUNT-1:0] r_heur_vld, n_heur_vld;
    logic                  r_adj_rv, r_heur_rv;
    logic                  r_cmp_go, n_cmp_go;
    logic [NW-1:0]         r_cmp_idx;
    logic                  r_out_valid, n_out_valid;
    logic [NODE_FW-1:0]    r_out_node, n_out_node;
    logic                  r_out_found, n_out_found;
    logic                  r_out_last, n_out_last;

    logic [NODE_FW-1:0] in_a, in_b;
    logic [HEUR_FW-1:0] in_h;
    logic               in_xfer;
    logic               a_ok, b_ok;

    logic                  adj_we, heur_we, par_we, path_we;
    logic [NW-1:0]         adj_waddr, adj_raddr, heur_waddr, heur_raddr;
    logic [NW-1:0]         par_waddr, path_raddr;
    logic [NODE_COUNT-1:0] adj_wdata, adj_rdata, adj_row;
    logic [HEUR_BITS-1:0]  heur_wdata, heur_rdata, heur_val;
    logic [NW-1:0]         par_rdata, path_rdata;
    logic [CW-1:0]         path_ridx;
    logic                  min_clear;
    logic [NW-1:0]         min_idx;
    logic                  scan_live;

    assign in_a    = s_axis_tdata[NODE_FW-1:0];
    assign in_b    = s_axis_tdata[2*NODE_FW-1:NODE_FW];
    assign in_h    = s_axis_tdata[2*NODE_FW+HEUR_FW-1:2*NODE_FW];
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign a_ok    = 32'(in_a) < NODE_COUNT;
    assign b_ok    = 32'(in_b) < NODE_COUNT;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_node);
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

    assign adj_row   = r_adj_rv ? adj_rdata : '0;
    assign heur_val  = r_heur_rv ? heur_rdata : '0;
    assign scan_live = (r_cnt < CW'(NODE_COUNT));
    assign path_ridx = r_len - CW'(1) - r_k;

    assign adj_raddr  = (r_state == S_PICK) ? min_idx : NW'(in_a);
    assign heur_raddr = scan_live ? r_cnt[NW-1:0] : '0;
    assign path_raddr = path_ridx[NW-1:0];

    gbfs_ram #(.DEPTH(NODE_COUNT), .WIDTH(NODE_COUNT)) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gbfs_ram #(.DEPTH(NODE_COUNT), .WIDTH(HEUR_BITS)) u_heur (
        .i_clk   (i_clk),
        .i_we    (heur_we),
        .i_waddr (heur_waddr),
        .i_wdata (heur_wdata),
        .i_raddr (heur_raddr),
        .o_rdata (heur_rdata)
    );

    gbfs_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_par (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (r_u),
        .i_raddr (r_x),
        .o_rdata (par_rdata)
    );

    gbfs_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_path (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (r_len[NW-1:0]),
        .i_wdata (r_x),
        .i_raddr (path_raddr),
        .o_rdata (path_rdata)
    );

    gbfs_minu #(.HW(HEUR_BITS), .NW(NW)) u_minu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (min_clear),
        .i_valid (r_cmp_go && r_open[r_cmp_idx]),
        .i_heur  (heur_val),
        .i_idx   (r_cmp_idx),
        .o_idx   (min_idx)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_axis_tuser)
                        CMD_EDGE:   n_state = (a_ok && b_ok) ? S_EDGE_RD : S_IDLE;
                        CMD_SEARCH: n_state = (a_ok && b_ok) ? S_SCAN : S_FAIL;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RD: n_state = S_IDLE;
            S_SCAN:    n_state = scan_live ? S_SCAN : S_PICK;
            S_PICK:    n_state = (min_idx == r_goal) ? S_BT_WR : S_ADJ_RD;
            S_ADJ_RD:  n_state = S_EXPAND;
            S_EXPAND: begin
                if (r_cnt == CW'(NODE_COUNT - 1)) begin
                    n_state = (r_open == '0) ? S_FAIL : S_SCAN;
                end
            end
            S_BT_WR: begin
                if (r_x == r_start || (r_len + CW'(1)) == CW'(NODE_COUNT)) begin
                    n_state = S_EM_RD;
                end else begin
                    n_state = S_BT_RD;
                end
            end
            S_BT_RD:  n_state = S_BT_WR;
            S_EM_RD:  n_state = S_EM_LD;
            S_EM_LD:  n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (m_axis_tready) begin
                    n_state = r_out_last ? S_IDLE : S_EM_RD;
                end
            end
            S_FAIL:   n_state = m_axis_tready ? S_IDLE : S_FAIL;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_k         = r_k;
        n_open      = r_open;
        n_closed    = r_closed;
        n_new       = r_new;
        n_u         = r_u;
        n_x         = r_x;
        n_start     = r_start;
        n_goal      = r_goal;
        n_ea        = r_ea;
        n_eb        = r_eb;
        n_adj_vld   = r_adj_vld;
        n_heur_vld  = r_heur_vld;
        n_cmp_go    = (r_state == S_SCAN) && scan_live;
        n_out_valid = r_out_valid;
        n_out_node  = r_out_node;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        adj_we      = 1'b0;
        adj_waddr   = r_ea;
        adj_wdata   = adj_row | (NODE_COUNT'(1) << r_eb);
        heur_we     = 1'b0;
        heur_waddr  = NW'(in_a);
        heur_wdata  = HEUR_BITS'(in_h);
        par_we      = 1'b0;
        par_waddr   = r_cnt[NW-1:0];
        path_we     = 1'b0;
        min_clear   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_axis_tuser)
                        CMD_CLEAR: begin
                            n_adj_vld  = '0;
                            n_heur_vld = '0;
                        end
                        CMD_SETH: begin
                            if (a_ok) begin
                                heur_we = 1'b1;
                                n_heur_vld[NW'(in_a)] = 1'b1;
                            end
                        end
                        CMD_EDGE: begin
                            n_ea = NW'(in_a);
                            n_eb = NW'(in_b);
                        end
                        default: begin
                            if (a_ok && b_ok) begin
                                n_start   = NW'(in_a);
                                n_goal    = NW'(in_b);
                                n_open    = NODE_COUNT'(1) << NW'(in_a);
                                n_closed  = '0;
                                n_cnt     = '0;
                                min_clear = 1'b1;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_node  = '0;
                                n_out_found = 1'b0;
                                n_out_last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_EDGE_RD: begin
                adj_we = 1'b1;
                n_adj_vld[r_ea] = 1'b1;
            end
            S_SCAN: begin
                if (scan_live) begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_PICK: begin
                n_u    = min_idx;
                n_x    = min_idx;
                n_len  = '0;
                n_open = r_open & ~(NODE_COUNT'(1) << min_idx);
                if (min_idx != r_goal) begin
                    n_closed = r_closed | (NODE_COUNT'(1) << min_idx);
                end
            end
            S_ADJ_RD: begin
                n_new  = adj_row & ~r_closed & ~r_open;
                n_open = r_open | (adj_row & ~r_closed & ~r_open);
                n_cnt  = '0;
            end
            S_EXPAND: begin
                par_we = r_new[r_cnt[NW-1:0]];
                if (r_cnt == CW'(NODE_COUNT - 1)) begin
                    n_cnt     = '0;
                    min_clear = 1'b1;
                    if (r_open == '0) begin
                        n_out_valid = 1'b1;
                        n_out_node  = '0;
                        n_out_found = 1'b0;
                        n_out_last  = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_BT_WR: begin
                path_we = 1'b1;
                n_len   = r_len + CW'(1);
                n_k     = '0;
            end
            S_BT_RD: begin
                n_x = par_rdata;
            end
            S_EM_LD: begin
                n_out_valid = 1'b1;
                n_out_node  = NODE_FW'(path_rdata);
                n_out_found = 1'b1;
                n_out_last  = (r_k + CW'(1)) == r_len;
            end
            S_EM_OUT: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    n_k         = r_k + CW'(1);
                end
            end
            S_FAIL: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_adj_vld   <= '0;
            r_heur_vld  <= '0;
            r_cmp_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_adj_vld   <= n_adj_vld;
            r_heur_vld  <= n_heur_vld;
            r_cmp_go    <= n_cmp_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_len       <= n_len;
        r_k         <= n_k;
        r_open      <= n_open;
        r_closed    <= n_closed;
        r_new       <= n_new;
        r_u         <= n_u;
        r_x         <= n_x;
        r_start     <= n_start;
        r_goal      <= n_goal;
        r_ea        <= n_ea;
        r_eb        <= n_eb;
        r_adj_rv    <= r_adj_vld[adj_raddr];
        r_heur_rv   <= r_heur_vld[heur_raddr];
        r_cmp_idx   <= heur_raddr;
        r_out_node  <= n_out_node;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

endmodule

FILE: src/gbfs_chk.sv
// Port-level checker for the best-first search block, bound to the top level.
module gbfs_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [gbfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic [gbfs_pkg::CMD_W-1:0]         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [gbfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                               m_axis_tuser,
    input logic                               m_axis_tlast
);
    import gbfs_pkg::*;

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("failure result not a single zero transfer");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready after final transfer");

endmodule

bind greedy_best_first_graph_search gbfs_chk u_gbfs_chk (.*);
